[design/lvsb_pkg.sv]
// ----------------------------------------------------------------------------
// lvsb_pkg: shared types and constants for the label volume statistics block
// Status codes, register indexes and the command word that drives the slot
// chain.
// ----------------------------------------------------------------------------
`default_nettype none

package lvsb_pkg;

    localparam int LABEL_W      = 32;
    localparam int RAW_W        = 33;
    localparam int CNT_W        = 37;
    localparam int DIM_W        = 13;
    localparam int OUT_COORD_W  = 12;
    localparam int PAL_W        = 3;
    localparam int PALETTE_SIZE = 6;

    typedef enum logic [1:0] {
        STATUS_LABEL     = 2'd0,
        STATUS_NO_LABELS = 2'd1,
        STATUS_RANGE     = 2'd2,
        STATUS_FULL      = 2'd3
    } status_t;

    typedef enum logic [1:0] {
        REG_DIM_X = 2'd0,
        REG_DIM_Y = 2'd1,
        REG_DIM_Z = 2'd2
    } reg_index_t;

    typedef enum logic [1:0] {
        CMD_IDLE  = 2'd0,
        CMD_VOXEL = 2'd1,
        CMD_POP   = 2'd2,
        CMD_CLEAR = 2'd3
    } cmd_mode_t;

    // Broadcast to every cell of the chain
    typedef struct packed {
        cmd_mode_t                  mode;
        logic                       upd;
        logic                       ins;
        logic signed [LABEL_W-1:0]  label;
    } cell_cmd_t;

endpackage

`default_nettype wire

[design/lvsb_cell.sv]
// ----------------------------------------------------------------------------
// lvsb_cell: one slot of the sorted label chain
// Holds one label with its voxel count and bounds. Updates in place on a
// match, takes its left neighbor or the new label on an insert, its right neighbor on a pop, and is emptied by a clear.
// ----------------------------------------------------------------------------
`default_nettype none

module lvsb_cell #(
    parameter int COORD_BITS = 12
) (
    input  wire                                   aclk,
    input  wire                                   aresetn,
    input  wire  lvsb_pkg::cell_cmd_t             cmd,
    input  wire  [COORD_BITS-1:0]                 x,
    input  wire  [COORD_BITS-1:0]                 y,
    input  wire  [COORD_BITS-1:0]                 z,
    input  wire                                   left_valid,
    input  wire                                   left_gt,
    input  wire  signed [lvsb_pkg::LABEL_W-1:0]   left_label,
    input  wire  [lvsb_pkg::CNT_W-1:0]            left_count,
    input  wire  [5:0][COORD_BITS-1:0]            left_bounds,
    input  wire                                   right_valid,
    input  wire  signed [lvsb_pkg::LABEL_W-1:0]   right_label,
    input  wire  [lvsb_pkg::CNT_W-1:0]            right_count,
    input  wire  [5:0][COORD_BITS-1:0]            right_bounds,
    output logic                                  valid_o,
    output logic                                  gt_o,
    output logic                                  hit_o,
    output logic signed [lvsb_pkg::LABEL_W-1:0]   label_o,
    output logic [lvsb_pkg::CNT_W-1:0]            count_o,
    output logic [5:0][COORD_BITS-1:0]            bounds_o
);
    import lvsb_pkg::*;

    logic                         valid_reg, valid_next;
    logic signed [LABEL_W-1:0]    label_reg, label_next;
    logic [CNT_W-1:0]             count_reg, count_next;
    logic [5:0][COORD_BITS-1:0]   bounds_reg, bounds_next;
    logic                         gt, hit;

    // Compare against the broadcast label
    assign gt  = !valid_reg || (label_reg > cmd.label);
    assign hit = valid_reg && (label_reg == cmd.label);

    // Select the next slot contents
    always_comb begin
        valid_next  = valid_reg;
        label_next  = label_reg;
        count_next  = count_reg;
        bounds_next = bounds_reg;
        unique case (cmd.mode)
            CMD_VOXEL: begin
                if (cmd.upd && hit) begin
                    count_next = count_reg + CNT_W'(1);
                    if (x < bounds_reg[0]) bounds_next[0] = x;
                    if (x > bounds_reg[1]) bounds_next[1] = x;
                    if (y < bounds_reg[2]) bounds_next[2] = y;
                    if (y > bounds_reg[3]) bounds_next[3] = y;
                    if (z < bounds_reg[4]) bounds_next[4] = z;
                    if (z > bounds_reg[5]) bounds_next[5] = z;
                end else if (cmd.ins && gt) begin
                    if (left_gt) begin
                        valid_next  = left_valid;
                        label_next  = left_label;
                        count_next  = left_count;
                        bounds_next = left_bounds;
                    end else begin
                        valid_next  = 1'b1;
                        label_next  = cmd.label;
                        count_next  = CNT_W'(1);
                        bounds_next = {z, z, y, y, x, x};
                    end
                end
            end
            CMD_POP: begin
                valid_next  = right_valid;
                label_next  = right_label;
                count_next  = right_count;
                bounds_next = right_bounds;
            end
            CMD_CLEAR: begin
                valid_next = 1'b0;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
        label_reg  <= label_next;
        count_reg  <= count_next;
        bounds_reg <= bounds_next;
    end

    assign valid_o  = valid_reg;
    assign gt_o     = gt;
    assign hit_o    = hit;
    assign label_o  = label_reg;
    assign count_o  = count_reg;
    assign bounds_o = bounds_reg;

endmodule

`default_nettype wire

[design/label_volume_stats_bbox.sv]
// ----------------------------------------------------------------------------
// label_volume_stats_bbox: per-label voxel count and bounding box of a volume
// Streams a raster-order label volume and reports one record per label.
// ----------------------------------------------------------------------------
// A voxel is taken whenever the block is not emitting and no result waits at
// the output: the label is compared against every slot of a sorted cell chain
// at once, and a new label is inserted by shifting the cells above it one
// place. After the final voxel the chain is popped from its low end, one
// record per cycle while the output is not stalled, in ascending label order;
// no voxel is taken during emission, and a volume with no labels yields a
// single no-labels result. An error result is registered for output when the
// failing voxel is taken; the rest of the volume is then consumed without results.
`default_nettype none

module label_volume_stats_bbox #(
    parameter int LABEL_SLOTS = 64,
    parameter int COORD_BITS  = 12
) (
    input  wire                                  aclk,
    input  wire                                  aresetn,
    input  wire                                  psel,
    input  wire                                  penable,
    input  wire                                  pwrite,
    input  wire  [3:0]                           paddr,
    input  wire  [31:0]                          pwdata,
    output logic [31:0]                          prdata,
    output logic                                 pready,
    input  wire                                  s_valid,
    output logic                                 s_ready,
    input  wire  signed [lvsb_pkg::RAW_W-1:0]    s_label_value,
    output logic                                 m_valid,
    input  wire                                  m_ready,
    output logic [1:0]                           m_status,
    output logic signed [lvsb_pkg::LABEL_W-1:0]  m_label_id,
    output logic [lvsb_pkg::CNT_W-1:0]           m_voxel_total,
    output logic [lvsb_pkg::OUT_COORD_W-1:0]     m_min_x,
    output logic [lvsb_pkg::OUT_COORD_W-1:0]     m_max_x,
    output logic [lvsb_pkg::OUT_COORD_W-1:0]     m_min_y,
    output logic [lvsb_pkg::OUT_COORD_W-1:0]     m_max_y,
    output logic [lvsb_pkg::OUT_COORD_W-1:0]     m_min_z,
    output logic [lvsb_pkg::OUT_COORD_W-1:0]     m_max_z,
    output logic [lvsb_pkg::PAL_W-1:0]           m_palette_index,
    output logic                                 m_last
);
    import lvsb_pkg::*;

    localparam int CNTW = $clog2(LABEL_SLOTS + 1);
    localparam logic [16:0] DIM_LIM = 17'(1 << COORD_BITS);

    typedef enum logic [1:0] {
        ST_RUN  = 2'b01,
        ST_EMIT = 2'b10
    } state_t;

    function automatic logic [COORD_BITS-1:0] last_index(input logic [DIM_W-1:0] d);
        logic [16:0] d17;
        d17 = 17'(d);
        if (d17 == 17'd0) return '0;
        else if (d17 > DIM_LIM) return '1;
        else return COORD_BITS'(d17 - 17'd1);
    endfunction

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    logic [DIM_W-1:0] dim_x_reg, dim_y_reg, dim_z_reg;
    logic             cfg_wr;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            dim_x_reg <= DIM_W'(1);
            dim_y_reg <= DIM_W'(1);
            dim_z_reg <= DIM_W'(1);
        end else if (cfg_wr) begin
            unique case (paddr[3:2])
                REG_DIM_X: dim_x_reg <= pwdata[DIM_W-1:0];
                REG_DIM_Y: dim_y_reg <= pwdata[DIM_W-1:0];
                REG_DIM_Z: dim_z_reg <= pwdata[DIM_W-1:0];
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        unique case (paddr[3:2])
            REG_DIM_X: prdata = 32'(dim_x_reg);
            REG_DIM_Y: prdata = 32'(dim_y_reg);
            REG_DIM_Z: prdata = 32'(dim_z_reg);
            default:   prdata = '0;
        endcase
    end

    // ------------------------------------------------------------------
    // Control state
    // ------------------------------------------------------------------
    state_t              state_reg, state_next;
    logic [COORD_BITS-1:0] pos_x_reg, pos_x_next, pos_y_reg, pos_y_next;
    logic [COORD_BITS-1:0] pos_z_reg, pos_z_next;
    logic                err_reg, err_next;
    logic [CNTW-1:0]     count_reg, count_next;
    logic [PAL_W-1:0]    pal_reg, pal_next;

    // Output register
    logic                     m_valid_reg, m_valid_next;
    logic                     out_load;
    status_t                  o_status_reg, o_status_next;
    logic signed [LABEL_W-1:0] o_label_reg, o_label_next;
    logic [CNT_W-1:0]         o_count_reg, o_count_next;
    logic [5:0][COORD_BITS-1:0] o_bounds_reg, o_bounds_next;
    logic [PAL_W-1:0]         o_pal_reg, o_pal_next;
    logic                     o_last_reg, o_last_next;

    // Chain signals
    cell_cmd_t                  cmd;
    logic [LABEL_SLOTS-1:0]     c_valid, c_gt, c_hit;
    logic signed [LABEL_W-1:0]  c_label  [LABEL_SLOTS];
    logic [CNT_W-1:0]           c_count  [LABEL_SLOTS];
    logic [5:0][COORD_BITS-1:0] c_bounds [LABEL_SLOTS];

    logic accept, out_free, final_vox, act, oor, full_err, hit_any, full;
    logic [COORD_BITS-1:0] lx, ly, lz;

    assign s_ready  = (state_reg == ST_RUN) && !m_valid_reg;
    assign accept   = s_valid && s_ready;
    assign out_free = !m_valid_reg || m_ready;
    assign hit_any  = |c_hit;
    assign full     = (count_reg == CNTW'(LABEL_SLOTS));
    assign lx       = last_index(dim_x_reg);
    assign ly       = last_index(dim_y_reg);
    assign lz       = last_index(dim_z_reg);

    // Classify the incoming voxel
    assign act      = !err_reg && (s_label_value != '0);
    assign oor      = act && (s_label_value[32] != s_label_value[31]);
    assign full_err = act && !oor && !hit_any && full;

    // Sequence voxels, errors and emission
    always_comb begin
        state_next    = state_reg;
        pos_x_next    = pos_x_reg;
        pos_y_next    = pos_y_reg;
        pos_z_next    = pos_z_reg;
        err_next      = err_reg;
        count_next    = count_reg;
        pal_next      = pal_reg;
        final_vox     = 1'b0;
        out_load      = 1'b0;
        o_status_next = o_status_reg;
        o_label_next  = o_label_reg;
        o_count_next  = o_count_reg;
        o_bounds_next = o_bounds_reg;
        o_pal_next    = o_pal_reg;
        o_last_next   = o_last_reg;
        cmd.mode      = CMD_IDLE;
        cmd.upd       = 1'b0;
        cmd.ins       = 1'b0;
        cmd.label     = s_label_value[LABEL_W-1:0];

        unique case (state_reg)
            ST_RUN: begin
                if (accept) begin
                    // advance the raster position
                    if (pos_x_reg < lx) begin
                        pos_x_next = pos_x_reg + COORD_BITS'(1);
                    end else begin
                        pos_x_next = '0;
                        if (pos_y_reg < ly) begin
                            pos_y_next = pos_y_reg + COORD_BITS'(1);
                        end else begin
                            pos_y_next = '0;
                            if (pos_z_reg < lz) begin
                                pos_z_next = pos_z_reg + COORD_BITS'(1);
                            end else begin
                                pos_z_next = '0;
                                final_vox  = 1'b1;
                            end
                        end
                    end

                    cmd.mode = CMD_VOXEL;
                    cmd.upd  = act && !oor && hit_any;
                    cmd.ins  = act && !oor && !hit_any && !full;
                    if (cmd.ins) count_next = count_reg + CNTW'(1);

                    // report an error at once
                    if (oor || full_err) begin
                        out_load      = 1'b1;
                        o_status_next = oor ? STATUS_RANGE : STATUS_FULL;
                        o_label_next  = oor ? '0 : s_label_value[LABEL_W-1:0];
                        o_count_next  = '0;
                        o_bounds_next = '0;
                        o_pal_next    = '0;
                        o_last_next   = 1'b1;
                        err_next      = 1'b1;
                    end

                    if (final_vox) begin
                        if (err_reg || oor || full_err) begin
                            cmd.mode   = CMD_CLEAR;
                            count_next = '0;
                            err_next   = 1'b0;
                        end else begin
                            state_next = ST_EMIT;
                        end
                    end
                end
            end
            ST_EMIT: begin
                if (out_free) begin
                    out_load = 1'b1;
                    if (count_reg == '0) begin
                        o_status_next = STATUS_NO_LABELS;
                        o_label_next  = '0;
                        o_count_next  = '0;
                        o_bounds_next = '0;
                        o_pal_next    = '0;
                        o_last_next   = 1'b1;
                        state_next    = ST_RUN;
                    end else begin
                        // pop the lowest label off the chain
                        cmd.mode      = CMD_POP;
                        o_status_next = STATUS_LABEL;
                        o_label_next  = c_label[0];
                        o_count_next  = c_count[0];
                        o_bounds_next = c_bounds[0];
                        o_pal_next    = pal_reg;
                        o_last_next   = (count_reg == CNTW'(1));
                        count_next    = count_reg - CNTW'(1);
                        pal_next      = (pal_reg == PAL_W'(PALETTE_SIZE - 1)) ?
                                        '0 : pal_reg + PAL_W'(1);
                        if (count_reg == CNTW'(1)) begin
                            state_next = ST_RUN;
                            pal_next   = '0;
                        end
                    end
                end
            end
            default: begin
                state_next = ST_RUN;
            end
        endcase
    end

    assign m_valid_next = out_load ? 1'b1 : (m_ready ? 1'b0 : m_valid_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_RUN;
            pos_x_reg   <= '0;
            pos_y_reg   <= '0;
            pos_z_reg   <= '0;
            err_reg     <= 1'b0;
            count_reg   <= '0;
            pal_reg     <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            pos_x_reg   <= pos_x_next;
            pos_y_reg   <= pos_y_next;
            pos_z_reg   <= pos_z_next;
            err_reg     <= err_next;
            count_reg   <= count_next;
            pal_reg     <= pal_next;
            m_valid_reg <= m_valid_next;
        end
        o_status_reg <= o_status_next;
        o_label_reg  <= o_label_next;
        o_count_reg  <= o_count_next;
        o_bounds_reg <= o_bounds_next;
        o_pal_reg    <= o_pal_next;
        o_last_reg   <= o_last_next;
    end

    // ------------------------------------------------------------------
    // Slot chain
    // ------------------------------------------------------------------
    for (genvar i = 0; i < LABEL_SLOTS; i++) begin : g_cell
        logic                       l_valid, l_gt, r_valid;
        logic signed [LABEL_W-1:0]  l_label, r_label;
        logic [CNT_W-1:0]           l_count, r_count;
        logic [5:0][COORD_BITS-1:0] l_bounds, r_bounds;

        if (i == 0) begin : g_head
            assign l_valid  = 1'b0;
            assign l_gt     = 1'b0;
            assign l_label  = '0;
            assign l_count  = '0;
            assign l_bounds = '0;
        end else begin : g_link_l
            assign l_valid  = c_valid[i-1];
            assign l_gt     = c_gt[i-1];
            assign l_label  = c_label[i-1];
            assign l_count  = c_count[i-1];
            assign l_bounds = c_bounds[i-1];
        end

        if (i == LABEL_SLOTS - 1) begin : g_tail
            assign r_valid  = 1'b0;
            assign r_label  = '0;
            assign r_count  = '0;
            assign r_bounds = '0;
        end else begin : g_link_r
            assign r_valid  = c_valid[i+1];
            assign r_label  = c_label[i+1];
            assign r_count  = c_count[i+1];
            assign r_bounds = c_bounds[i+1];
        end

        lvsb_cell #(
            .COORD_BITS (COORD_BITS)
        ) u_cell (
            .aclk         (aclk),
            .aresetn      (aresetn),
            .cmd          (cmd),
            .x            (pos_x_reg),
            .y            (pos_y_reg),
            .z            (pos_z_reg),
            .left_valid   (l_valid),
            .left_gt      (l_gt),
            .left_label   (l_label),
            .left_count   (l_count),
            .left_bounds  (l_bounds),
            .right_valid  (r_valid),
            .right_label  (r_label),
            .right_count  (r_count),
            .right_bounds (r_bounds),
            .valid_o      (c_valid[i]),
            .gt_o         (c_gt[i]),
            .hit_o        (c_hit[i]),
            .label_o      (c_label[i]),
            .count_o      (c_count[i]),
            .bounds_o     (c_bounds[i])
        );
    end

    // Drive the result ports
    assign m_valid         = m_valid_reg;
    assign m_status        = o_status_reg;
    assign m_label_id      = o_label_reg;
    assign m_voxel_total   = o_count_reg;
    assign m_min_x         = OUT_COORD_W'(o_bounds_reg[0]);
    assign m_max_x         = OUT_COORD_W'(o_bounds_reg[1]);
    assign m_min_y         = OUT_COORD_W'(o_bounds_reg[2]);
    assign m_max_y         = OUT_COORD_W'(o_bounds_reg[3]);
    assign m_min_z         = OUT_COORD_W'(o_bounds_reg[4]);
    assign m_max_z         = OUT_COORD_W'(o_bounds_reg[5]);
    assign m_palette_index = o_pal_reg;
    assign m_last          = o_last_reg;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    a_count_matches_cells: assert property (@(posedge aclk) disable iff (!aresetn)
        $countones(c_valid) == int'(count_reg))
        else $error("slot count disagrees with occupied cells");

    a_record_nonempty: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg && (o_status_reg == STATUS_LABEL) |-> (o_count_reg != '0))
        else $error("label record with zero voxels");

    a_error_is_last: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg && (o_status_reg != STATUS_LABEL) |-> o_last_reg)
        else $error("error or empty result not marked last");

    a_emit_ends_clear: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_EMIT) && (state_next == ST_RUN) |=> (count_reg == '0))
        else $error("chain not empty after emission");

endmodule

`default_nettype wire
